[rtl/length_framed_byte_deframer_core_macros.svh]
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms for the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef LENGTH_FRAMED_BYTE_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_FRAMED_BYTE_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LFBD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled during reset.
`define LFBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

[rtl/lfbd_pkg.sv]
// ----------------------------------------------------------------------------
// Deframer package
// Types and fixed constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lfbd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned FRAME_LEN_W = 32;
  localparam int unsigned HDR_CNT_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [HDR_CNT_W-1:0] HDR_LAST     = 3'd7;
  localparam logic [HDR_CNT_W-1:0] HDR_MARK_POS = 3'd0;
  localparam logic [HDR_CNT_W-1:0] HDR_TYPE_POS = 3'd1;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_POS  = 3'd4;

  localparam logic [BYTE_W-1:0] HEAD_MARKER_RST   = 8'h55;
  localparam logic [BYTE_W-1:0] TAIL_MARKER_RST   = 8'hAA;
  localparam logic [BYTE_W-1:0] EXPECTED_TYPE_RST = 8'h01;
  localparam logic [LEN_W-1:0]  MAX_CONTENT_RST   = 11'd2046;
  localparam logic [LEN_W-1:0]  LEN_SAT           = 11'd2047;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_MARKER   = 3'd0,
    REG_TAIL_MARKER   = 3'd1,
    REG_EXPECTED_TYPE = 3'd2,
    REG_MAX_CONTENT   = 3'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_CHECK   = 2'd2,
    PH_TAIL    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_BAD_TAIL = 3'd3,
    ST_ZERO_LEN = 3'd4,
    ST_TOO_LONG = 3'd5,
    ST_HALTED   = 3'd6
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] head_marker;
    logic [BYTE_W-1:0] tail_marker;
    logic [BYTE_W-1:0] expected_type;
    logic [LEN_W-1:0]  max_content;
  } cfg_t;

  typedef struct packed {
    phase_t                 phase;
    logic [HDR_CNT_W-1:0]   header_count;
    logic [FRAME_LEN_W-1:0] frame_length;
    logic [LEN_W-1:0]       content_count;
    logic [BYTE_W-1:0]      running_xor;
    logic [BYTE_W-1:0]      received_check;
    logic                   head_warn;
    logic                   type_warn;
    logic                   halted;
  } parse_state_t;

  typedef struct packed {
    logic              content_valid;
    logic [BYTE_W-1:0] content_byte;
    logic              frame_end;
    status_t           frame_status;
    logic              head_marker_bad;
    logic              type_bad;
    logic [LEN_W-1:0]  content_length;
  } result_t;

endpackage

`default_nettype wire

[rtl/lfbd_if.sv]
// ----------------------------------------------------------------------------
// Deframer channel interfaces
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfbd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [lfbd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfbd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        content_valid;
  logic [lfbd_pkg::BYTE_W-1:0] content_byte;
  logic                        frame_end;
  logic [2:0]                  frame_status;
  logic                        head_marker_bad;
  logic                        type_bad;
  logic [lfbd_pkg::LEN_W-1:0]  content_length;

  modport source (output valid, output content_valid, output content_byte,
                  output frame_end, output frame_status, output head_marker_bad,
                  output type_bad, output content_length, input ready);
  modport sink   (input valid, input content_valid, input content_byte,
                  input frame_end, input frame_status, input head_marker_bad,
                  input type_bad, input content_length, output ready);
endinterface

interface lfbd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lfbd_pkg::CFG_IDX_W-1:0]  index;
  logic [lfbd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/length_framed_byte_deframer_core.sv]
// ----------------------------------------------------------------------------
// Length-framed byte deframer
// Parses header / content / checksum / tail frames from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   rx     : one received byte per transaction (valid/ready).
//   result : exactly one result per accepted byte: content byte pass-through
//            while in the content, an end-of-frame status on the tail byte
//            or on a header that aborts, busy otherwise, halted once stopped.
//   cfg    : register writes (index, data); always ready. Write only while
//            the block is idle.
// Output: the result of a byte is registered and shown in the cycle after it is accepted.
// Throughput: one byte per cycle while results are taken; the whole parse step is one
//   combinational pass from the state registers into the result register.
// Reset: rst (synchronous) restores the config registers, the result valid
//   flag and the parser to the start of a header and clears the halted flag.
// Stall: while a result waits on result.ready the block still takes one
//   more byte only if the result register is freed in the same cycle;
//   otherwise rx.ready drops and the parser state holds.
// Halt: a zero length, a length above the limit or a bad tail marker stops
//   parsing; every later byte returns the halted status until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module length_framed_byte_deframer_core #(
  parameter int unsigned BUFFER_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst,
  lfbd_byte_if.sink           rx,
  lfbd_result_if.source       result,
  lfbd_cfg_if.sink            cfg
);

  // Content plus checksum and tail must fit the receive buffer.
  localparam int unsigned BUF_LIM = BUFFER_BYTES - 2;

  lfbd_pkg::cfg_t          cfg_reg;
  lfbd_pkg::parse_state_t  state;
  lfbd_pkg::parse_state_t  state_next;
  lfbd_pkg::result_t       res_next;
  lfbd_pkg::result_t       res_reg;
  logic                    res_valid;
  logic [lfbd_pkg::LEN_W-1:0] limit;
  logic                    rx_fire;

  // Result register frees when taken, so a byte can enter every cycle while results are taken.
  assign rx.ready  = !res_valid || result.ready;
  assign rx_fire   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  // Effective length limit: the smaller of the register and the buffer bound.
  assign limit = (BUF_LIM < 32'(cfg_reg.max_content)) ? lfbd_pkg::LEN_W'(BUF_LIM)
                                                       : cfg_reg.max_content;

  // Register file; unknown indexes drop the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.head_marker   <= lfbd_pkg::HEAD_MARKER_RST;
      cfg_reg.tail_marker   <= lfbd_pkg::TAIL_MARKER_RST;
      cfg_reg.expected_type <= lfbd_pkg::EXPECTED_TYPE_RST;
      cfg_reg.max_content   <= lfbd_pkg::MAX_CONTENT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        lfbd_pkg::REG_HEAD_MARKER:
          cfg_reg.head_marker <= cfg.data[lfbd_pkg::BYTE_W-1:0];
        lfbd_pkg::REG_TAIL_MARKER:
          cfg_reg.tail_marker <= cfg.data[lfbd_pkg::BYTE_W-1:0];
        lfbd_pkg::REG_EXPECTED_TYPE:
          cfg_reg.expected_type <= cfg.data[lfbd_pkg::BYTE_W-1:0];
        lfbd_pkg::REG_MAX_CONTENT:
          cfg_reg.max_content <= cfg.data[lfbd_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lfbd_parse u_parse (
    .state      (state),
    .cfg        (cfg_reg),
    .limit      (limit),
    .rx_byte    (rx.rx_byte),
    .state_next (state_next),
    .res        (res_next)
  );

  // Parser state: advance only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= lfbd_pkg::PH_HEADER;
      state.header_count   <= '0;
      state.frame_length   <= '0;
      state.content_count  <= '0;
      state.running_xor    <= '0;
      state.received_check <= '0;
      state.head_warn      <= 1'b0;
      state.type_warn      <= 1'b0;
      state.halted         <= 1'b0;
    end else if (rx_fire) begin
      state <= state_next;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire) begin
      res_reg <= res_next;
    end
  end

  assign result.valid           = res_valid;
  assign result.content_valid   = res_reg.content_valid;
  assign result.content_byte    = res_reg.content_byte;
  assign result.frame_end       = res_reg.frame_end;
  assign result.frame_status    = res_reg.frame_status;
  assign result.head_marker_bad = res_reg.head_marker_bad;
  assign result.type_bad        = res_reg.type_bad;
  assign result.content_length  = res_reg.content_length;

endmodule

`default_nettype wire

[rtl/lfbd_parse.sv]
// ----------------------------------------------------------------------------
// Deframer parse step
// Next parser state and result for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lfbd_parse (
  input  lfbd_pkg::parse_state_t          state,
  input  lfbd_pkg::cfg_t                  cfg,
  input  logic [lfbd_pkg::LEN_W-1:0]      limit,
  input  logic [lfbd_pkg::BYTE_W-1:0]     rx_byte,
  output lfbd_pkg::parse_state_t          state_next,
  output lfbd_pkg::result_t               res
);

  logic [lfbd_pkg::FRAME_LEN_W-1:0] len_shift;
  logic [lfbd_pkg::FRAME_LEN_W-1:0] len_new;
  logic [lfbd_pkg::LEN_W-1:0]       count_inc;
  logic                             len_zero;
  logic                             len_long;
  logic                             tail_bad;

  assign len_shift = {state.frame_length[lfbd_pkg::FRAME_LEN_W-lfbd_pkg::BYTE_W-1:0], rx_byte};
  assign len_new   = (state.header_count >= lfbd_pkg::HDR_LEN_POS) ? len_shift
                                                                   : state.frame_length;
  assign count_inc = state.content_count + 1'b1;
  assign len_zero  = (len_new == '0);
  assign len_long  = (len_new > {{(lfbd_pkg::FRAME_LEN_W-lfbd_pkg::LEN_W){1'b0}}, limit});
  assign tail_bad  = (rx_byte != cfg.tail_marker);

  // Next state
  always_comb begin
    state_next = state;
    if (!state.halted) begin
      unique case (state.phase)
        lfbd_pkg::PH_HEADER: begin
          if (state.header_count == lfbd_pkg::HDR_MARK_POS) begin
            state_next.head_warn = (rx_byte != cfg.head_marker);
          end else if (state.header_count == lfbd_pkg::HDR_TYPE_POS) begin
            state_next.type_warn = (rx_byte != cfg.expected_type);
          end
          state_next.frame_length = len_new;
          if (state.header_count == lfbd_pkg::HDR_LAST) begin
            state_next.header_count  = '0;
            state_next.running_xor   = '0;
            state_next.content_count = '0;
            if (len_zero || len_long) begin
              state_next.halted = 1'b1;
            end else begin
              state_next.phase = lfbd_pkg::PH_CONTENT;
            end
          end else begin
            state_next.header_count = state.header_count + 1'b1;
          end
        end
        lfbd_pkg::PH_CONTENT: begin
          state_next.running_xor   = state.running_xor ^ rx_byte;
          state_next.content_count = count_inc;
          if ({{(lfbd_pkg::FRAME_LEN_W-lfbd_pkg::LEN_W){1'b0}}, count_inc}
              >= state.frame_length) begin
            state_next.phase = lfbd_pkg::PH_CHECK;
          end
        end
        lfbd_pkg::PH_CHECK: begin
          state_next.received_check = rx_byte;
          state_next.phase          = lfbd_pkg::PH_TAIL;
        end
        lfbd_pkg::PH_TAIL: begin
          if (tail_bad) begin
            state_next.halted = 1'b1;
          end
          state_next.phase        = lfbd_pkg::PH_HEADER;
          state_next.header_count = '0;
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  // Result
  always_comb begin
    res = '0;
    res.frame_status = lfbd_pkg::ST_BUSY;
    if (state.halted) begin
      res.frame_status = lfbd_pkg::ST_HALTED;
    end else begin
      unique case (state.phase)
        lfbd_pkg::PH_HEADER: begin
          if (state.header_count == lfbd_pkg::HDR_LAST && (len_zero || len_long)) begin
            res.frame_end    = 1'b1;
            res.frame_status = len_zero ? lfbd_pkg::ST_ZERO_LEN : lfbd_pkg::ST_TOO_LONG;
          end
        end
        lfbd_pkg::PH_CONTENT: begin
          res.content_valid = 1'b1;
          res.content_byte  = rx_byte;
        end
        lfbd_pkg::PH_CHECK: begin
          res.frame_end = 1'b0;
        end
        lfbd_pkg::PH_TAIL: begin
          res.frame_end = 1'b1;
          if (tail_bad) begin
            res.frame_status = lfbd_pkg::ST_BAD_TAIL;
          end else if (state.received_check != state.running_xor) begin
            res.frame_status = lfbd_pkg::ST_CHECKSUM;
          end else begin
            res.frame_status = lfbd_pkg::ST_OK;
          end
        end
        default: begin
          res.frame_end = 1'b0;
        end
      endcase
      if (res.frame_end) begin
        res.head_marker_bad = state_next.head_warn;
        res.type_bad        = state_next.type_warn;
        res.content_length  =
          (|state_next.frame_length[lfbd_pkg::FRAME_LEN_W-1:lfbd_pkg::LEN_W])
            ? lfbd_pkg::LEN_SAT
            : state_next.frame_length[lfbd_pkg::LEN_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/lfbd_checker.sv]
// ----------------------------------------------------------------------------
// Deframer port checker
// Port-level assertions, bound to the deframer top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_framed_byte_deframer_core_macros.svh"

module lfbd_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rx_ready,
  input  logic                        res_valid,
  input  logic                        res_ready,
  input  logic                        content_valid,
  input  logic [lfbd_pkg::BYTE_W-1:0] content_byte,
  input  logic                        frame_end,
  input  logic [2:0]                  frame_status,
  input  logic                        head_marker_bad,
  input  logic                        type_bad,
  input  logic [lfbd_pkg::LEN_W-1:0]  content_length
);

  // Input stalls only behind a result that is not being taken.
  `LFBD_ASSERT_IMPLIES(a_rx_stall_cause, clk, rst, !rx_ready, res_valid && !res_ready)

  // A waiting result holds its payload.
  `LFBD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(content_byte) && $stable(frame_status) && $stable(content_length))

  // Content bytes never carry frame end information.
  `LFBD_ASSERT_IMPLIES(a_content_busy, clk, rst, res_valid && content_valid,
    !frame_end && frame_status == lfbd_pkg::ST_BUSY)

  // Outside a frame end only busy or halted, with the end fields cleared.
  `LFBD_ASSERT_IMPLIES(a_no_end_fields, clk, rst, res_valid && !frame_end,
    (frame_status == lfbd_pkg::ST_BUSY || frame_status == lfbd_pkg::ST_HALTED) &&
    !head_marker_bad && !type_bad && content_length == '0)

endmodule

bind length_framed_byte_deframer_core lfbd_checker u_lfbd_checker (
  .clk             (clk),
  .rst             (rst),
  .rx_ready        (rx.ready),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .content_valid   (result.content_valid),
  .content_byte    (result.content_byte),
  .frame_end       (result.frame_end),
  .frame_status    (result.frame_status),
  .head_marker_bad (result.head_marker_bad),
  .type_bad        (result.type_bad),
  .content_length  (result.content_length)
);

`default_nettype wire
